// ===== rtl/hog_cell_orientation_histogram_macros.svh =====
// ----------------------------------------------------------------------------
// hog cell histogram assertion macros
// shared assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HOG_CELL_ORIENTATION_HISTOGRAM_MACROS_SVH
`define HOG_CELL_ORIENTATION_HISTOGRAM_MACROS_SVH
`ifndef SYNTH
`define HOG_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HOG_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HOG_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define HOG_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/hog_pkg.sv =====
// ----------------------------------------------------------------------------
// hog package
// shared types and constants of the cell histogram
// ----------------------------------------------------------------------------
package hog_pkg;
    localparam int BIN_COUNT = 9;
    localparam int CNT_W     = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [35:0] TAN20 = 36'd1563240253;
    localparam logic [35:0] TAN40 = 36'd3603905474;
    localparam logic [35:0] TAN60 = 36'd7439101574;
    localparam logic [35:0] TAN80 = 36'd24357969942;
    localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_CELL_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_CELL_HEIGHT = 2'd2;

    // front to back queue entry
    typedef struct packed {
        logic [3:0] bin;
        logic [5:0] cell_idx;
        logic       counted;
        logic       row_end;
        logic [6:0] ncells;
    } hog_cmd_t;

    typedef logic [BIN_COUNT*CNT_W-1:0] hog_row_t;
endpackage

// ===== rtl/hog_ram.sv =====
// ----------------------------------------------------------------------------
// hog generic ram
// single write port, single registered read port
// ----------------------------------------------------------------------------
module hog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ===== rtl/hog_front.sv =====
// ----------------------------------------------------------------------------
// hog front end
// gradient, orientation bin and cell index, two register stages
// ----------------------------------------------------------------------------
module hog_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [10:0]         image_width,
    input  logic [4:0]          cell_width,
    input  logic [4:0]          cell_height,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          left_pixel,
    input  logic [7:0]          right_pixel,
    input  logic [7:0]          up_pixel,
    input  logic [7:0]          down_pixel,
    input  logic [9:0]          pixel_col,
    input  logic [9:0]          pixel_row,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output hog_pkg::hog_cmd_t   cmd
);
    import hog_pkg::*;

    // stage 1: gradients and products
    logic        s1_valid_reg;
    logic        s1_neg_reg;
    logic [39:0] s1_ay_reg;
    logic [43:0] s1_p_reg [4];
    logic [9:0]  s1_col_reg;
    logic [9:0]  s1_row_reg;
    logic [27:0] s1_colq_reg;
    logic [27:0] s1_rowq_reg;
    logic [27:0] s1_ncq_reg;
    // stage 2: output
    logic        s2_valid_reg;
    hog_cmd_t    s2_cmd_reg;

    logic [4:0]  cw;
    logic [4:0]  ch;
    logic [7:0]  ax;
    logic [7:0]  ay;
    logic        neg_x;
    logic [2:0]  above;
    logic [3:0]  bin;
    logic [10:0] ncells_w;
    logic [6:0]  ncells;
    logic [9:0]  cell_q;
    logic [10:0] row_q;
    logic        row_hit;
    logic        adv2;
    logic        adv1;

    // ceil(2^16 / d): n * recip(d) >> 16 is the exact quotient for n up to 2047
    function automatic logic [16:0] recip(input logic [4:0] d);
        logic [16:0] r;
        case (d)
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4096;
            5'd17:   r = 17'd3856;
            5'd18:   r = 17'd3641;
            5'd19:   r = 17'd3450;
            5'd20:   r = 17'd3277;
            5'd21:   r = 17'd3121;
            5'd22:   r = 17'd2979;
            5'd23:   r = 17'd2850;
            5'd24:   r = 17'd2731;
            5'd25:   r = 17'd2622;
            5'd26:   r = 17'd2521;
            5'd27:   r = 17'd2428;
            5'd28:   r = 17'd2341;
            5'd29:   r = 17'd2260;
            5'd30:   r = 17'd2185;
            5'd31:   r = 17'd2115;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    assign cw = (cell_width == 5'd0) ? 5'd1 : cell_width;
    assign ch = (cell_height == 5'd0) ? 5'd1 : cell_height;
    assign neg_x = right_pixel < left_pixel;
    assign ax = neg_x ? left_pixel - right_pixel : right_pixel - left_pixel;
    assign ay = (down_pixel >= up_pixel) ? down_pixel - up_pixel : up_pixel - down_pixel;

    assign adv2 = !s2_valid_reg || cmd_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_neg_reg <= neg_x;
            s1_ay_reg  <= {ay, 32'd0};
            s1_p_reg[0] <= 44'(ax) * TAN20;
            s1_p_reg[1] <= 44'(ax) * TAN40;
            s1_p_reg[2] <= 44'(ax) * TAN60;
            s1_p_reg[3] <= 44'(ax) * TAN80;
            s1_col_reg <= pixel_col;
            s1_row_reg <= pixel_row;
            s1_colq_reg <= 28'(pixel_col) * 28'(recip(cw));
            s1_rowq_reg <= 28'(11'(pixel_row) + 11'd1) * 28'(recip(ch));
            s1_ncq_reg  <= 28'(10'(image_width - 11'd1)) * 28'(recip(cw));
        end
    end

    always_comb begin
        above = 3'((44'(s1_ay_reg) > s1_p_reg[0]) ? 1 : 0)
              + 3'((44'(s1_ay_reg) > s1_p_reg[1]) ? 1 : 0)
              + 3'((44'(s1_ay_reg) > s1_p_reg[2]) ? 1 : 0)
              + 3'((44'(s1_ay_reg) > s1_p_reg[3]) ? 1 : 0);
        bin = s1_neg_reg ? 4'd8 - {1'b0, above} : {1'b0, above};
        cell_q = s1_colq_reg[25:16];
        row_q  = s1_rowq_reg[26:16];
        row_hit = (11'(s1_col_reg) + 11'd1 == image_width)
                && (row_q * 11'(ch) == 11'(s1_row_reg) + 11'd1);
        ncells_w = 11'(s1_ncq_reg[25:16]) + 11'd1;
        ncells = (ncells_w > 11'd64) ? 7'd64 : 7'(ncells_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= in_valid;
            end
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_cmd_reg.bin      <= bin;
            s2_cmd_reg.cell_idx <= cell_q[5:0];
            s2_cmd_reg.counted  <= cell_q < 10'd64;
            s2_cmd_reg.row_end  <= row_hit;
            s2_cmd_reg.ncells   <= ncells;
        end
    end

    assign cmd_valid = s2_valid_reg;
    assign cmd = s2_cmd_reg;
endmodule

// ===== rtl/hog_back.sv =====
// ----------------------------------------------------------------------------
// hog back end
// read-modify-write of the cell counters and row emission with clearing
// ----------------------------------------------------------------------------
`include "hog_cell_orientation_histogram_macros.svh"
module hog_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  hog_pkg::hog_cmd_t   cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output hog_pkg::hog_row_t   out_counts,
    output logic [5:0]          out_cell,
    output logic                out_last
);
    import hog_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]  state_reg;
    logic [6:0]  emit_reg;
    logic [6:0]  ncells_reg;
    logic [63:0] valid_reg;
    logic        ovalid_reg;
    hog_row_t    ocnt_reg;
    logic [5:0]  ocell_reg;
    logic        olast_reg;

    // single row word per cell, updated by read-modify-write
    logic        upd_reg;
    hog_cmd_t    upd_cmd_reg;

    logic        we;
    logic [5:0]  waddr;
    hog_row_t    wdata;
    logic [5:0]  raddr;
    hog_row_t    rdata;
    hog_row_t    cur;
    logic [CNT_W-1:0] c_old;
    logic        emit_done;

    hog_ram #(.WIDTH(BIN_COUNT*CNT_W), .DEPTH(64)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign cmd_ready = (state_reg == ST_RUN) && !upd_reg;
    assign raddr = (state_reg == ST_RUN) ? cmd.cell_idx : emit_reg[5:0];
    assign emit_done = (state_reg == ST_WAIT) && (!ovalid_reg || out_ready)
                     && (emit_reg + 7'd1 == ncells_reg);

    always_comb begin
        cur = valid_reg[upd_cmd_reg.cell_idx] ? rdata : '0;
        c_old = cur[upd_cmd_reg.bin*CNT_W +: CNT_W];
        wdata = cur;
        if (c_old != COUNT_MAX) begin
            wdata[upd_cmd_reg.bin*CNT_W +: CNT_W] = c_old + 9'd1;
        end
        we = upd_reg && upd_cmd_reg.counted;
        waddr = upd_cmd_reg.cell_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            upd_reg     <= 1'b0;
            valid_reg   <= '0;
            ovalid_reg  <= 1'b0;
            emit_reg    <= '0;
        end else begin
            // the wait state reloads the output itself when it moves
            if (ovalid_reg && out_ready && state_reg != ST_WAIT) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN: begin
                    upd_reg <= cmd_valid && cmd_ready;
                    if (cmd_valid && cmd_ready) begin
                        upd_cmd_reg <= cmd;
                    end
                    if (upd_reg) begin
                        if (upd_cmd_reg.counted) begin
                            valid_reg[upd_cmd_reg.cell_idx] <= 1'b1;
                        end
                        if (upd_cmd_reg.row_end) begin
                            state_reg   <= ST_EMIT;
                            emit_reg    <= '0;
                            ncells_reg  <= upd_cmd_reg.ncells;
                        end
                    end
                end
                ST_EMIT: begin
                    // read issued this cycle for emit_reg, data next cycle
                    state_reg   <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (!ovalid_reg || out_ready) begin
                        ovalid_reg <= 1'b1;
                        ocnt_reg   <= valid_reg[emit_reg[5:0]] ? rdata : '0;
                        ocell_reg  <= emit_reg[5:0];
                        olast_reg  <= emit_reg + 7'd1 == ncells_reg;
                        if (emit_reg + 7'd1 == ncells_reg) begin
                            state_reg <= ST_RUN;
                            valid_reg <= '0;
                        end else begin
                            emit_reg  <= emit_reg + 7'd1;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_counts = ocnt_reg;
    assign out_cell   = ocell_reg;
    assign out_last   = olast_reg;

    `HOG_ASSERT_NEVER(a_no_take_emit, aclk, aresetn, cmd_ready && state_reg != ST_RUN, "take during emit")
    `HOG_ASSERT_IMPL(a_emit_wait, aclk, aresetn, state_reg == ST_EMIT |=> state_reg == ST_WAIT, "emit seq")
    `HOG_ASSERT_IMPL(a_last_ends, aclk, aresetn, emit_done |=> valid_reg == '0, "row not cleared")
    `HOG_ASSERT_NEVER(a_rmw_busy, aclk, aresetn, upd_reg && cmd_ready, "overlapped update")
endmodule

// ===== rtl/hog_cell_orientation_histogram.sv =====
// ----------------------------------------------------------------------------
// hog cell orientation histogram
// nine bin orientation histogram per cell, one cell row of counters
// ----------------------------------------------------------------------------
// channel   prefix  payload
// pixel in  s_      four neighbours, column, row
// cell out  m_      nine bin counts, cell column, row done
//
// a pixel is classified by a two stage front end and counted by a
// read-modify-write of its cell word, no new pixel taken until it is written
// on the last pixel of a cell row each cell is emitted in turn, read then sent
// sync active low reset clears counters at once through per-cell valid bits
// output stalls hold the input only during row emission, via the command queue
// ----------------------------------------------------------------------------
module hog_cell_orientation_histogram (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_left_pixel,
    input  logic [7:0]  s_right_pixel,
    input  logic [7:0]  s_up_pixel,
    input  logic [7:0]  s_down_pixel,
    input  logic [9:0]  s_pixel_col,
    input  logic [9:0]  s_pixel_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_count_bin0,
    output logic [8:0]  m_count_bin1,
    output logic [8:0]  m_count_bin2,
    output logic [8:0]  m_count_bin3,
    output logic [8:0]  m_count_bin4,
    output logic [8:0]  m_count_bin5,
    output logic [8:0]  m_count_bin6,
    output logic [8:0]  m_count_bin7,
    output logic [8:0]  m_count_bin8,
    output logic [5:0]  m_cell_col,
    output logic        m_row_done
);
    import hog_pkg::*;

    logic [10:0] image_width_reg;
    logic [4:0]  cell_width_reg;
    logic [4:0]  cell_height_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= 11'd64;
            cell_width_reg  <= 5'd8;
            cell_height_reg <= 5'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                CFG_CELL_WIDTH:  cell_width_reg  <= cfg_data[4:0];
                CFG_CELL_HEIGHT: cell_height_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic     cmd_valid;
    logic     cmd_ready;
    hog_cmd_t cmd;
    hog_row_t counts;

    // front end: stage registers act as the queue to the back end
    hog_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .image_width(image_width_reg), .cell_width(cell_width_reg),
        .cell_height(cell_height_reg),
        .in_valid(s_valid), .in_ready(s_ready),
        .left_pixel(s_left_pixel), .right_pixel(s_right_pixel),
        .up_pixel(s_up_pixel), .down_pixel(s_down_pixel),
        .pixel_col(s_pixel_col), .pixel_row(s_pixel_row),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    // back end: counter update and row emission
    hog_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out_valid(m_valid), .out_ready(m_ready), .out_counts(counts),
        .out_cell(m_cell_col), .out_last(m_row_done)
    );

    assign m_count_bin0 = counts[0*CNT_W +: CNT_W];
    assign m_count_bin1 = counts[1*CNT_W +: CNT_W];
    assign m_count_bin2 = counts[2*CNT_W +: CNT_W];
    assign m_count_bin3 = counts[3*CNT_W +: CNT_W];
    assign m_count_bin4 = counts[4*CNT_W +: CNT_W];
    assign m_count_bin5 = counts[5*CNT_W +: CNT_W];
    assign m_count_bin6 = counts[6*CNT_W +: CNT_W];
    assign m_count_bin7 = counts[7*CNT_W +: CNT_W];
    assign m_count_bin8 = counts[8*CNT_W +: CNT_W];
endmodule

// ===== bench/hog_cell_orientation_histogram_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hog cell orientation histogram testbench
// drives pixel requests with random gaps and stalls the cell output at
// random; a behavioral model of the nine bin cell histogram predicts every
// emitted cell, which is compared field by field in order of arrival
// ----------------------------------------------------------------------------
module hog_cell_orientation_histogram_test;
    import hog_pkg::*;

    localparam int MAX_CELLS   = 64;
    localparam int SETTLE      = 400;   // cycles to let a no-output pixel finish
    localparam int STALL_LIMIT = 6000;  // cycles with no request moving

    // one emitted cell
    typedef struct packed {
        logic [BIN_COUNT-1:0][CNT_W-1:0] counts;
        logic [5:0]                      cell_idx;
        logic                            last;
    } cell_hist_t;

    // directed pixel, want_bin < 0 means the model decides
    typedef struct {
        int unsigned l, r, u, d;
        int          want_bin;
    } grad_case_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [10:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_left_pixel = '0;
    logic [7:0]  s_right_pixel = '0;
    logic [7:0]  s_up_pixel = '0;
    logic [7:0]  s_down_pixel = '0;
    logic [9:0]  s_pixel_col = '0;
    logic [9:0]  s_pixel_row = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [8:0]  m_count_bin0, m_count_bin1, m_count_bin2, m_count_bin3, m_count_bin4;
    logic [8:0]  m_count_bin5, m_count_bin6, m_count_bin7, m_count_bin8;
    logic [5:0]  m_cell_col;
    logic        m_row_done;

    hog_cell_orientation_histogram i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_pixel  (s_left_pixel),
        .s_right_pixel (s_right_pixel),
        .s_up_pixel    (s_up_pixel),
        .s_down_pixel  (s_down_pixel),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count_bin0  (m_count_bin0),
        .m_count_bin1  (m_count_bin1),
        .m_count_bin2  (m_count_bin2),
        .m_count_bin3  (m_count_bin3),
        .m_count_bin4  (m_count_bin4),
        .m_count_bin5  (m_count_bin5),
        .m_count_bin6  (m_count_bin6),
        .m_count_bin7  (m_count_bin7),
        .m_count_bin8  (m_count_bin8),
        .m_cell_col    (m_cell_col),
        .m_row_done    (m_row_done)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // model state: one row of cell counters and the register copies
    logic [CNT_W-1:0] hist_model [MAX_CELLS][BIN_COUNT];
    logic [10:0]      width_reg  = 11'd64;
    logic [4:0]       cellw_reg  = 5'd8;
    logic [4:0]       cellh_reg  = 5'd8;
    cell_hist_t       pending_cells [$];
    int               errors = 0;
    bit               calm = 1'b0;     // no idling on either side while set

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // unsigned orientation bin by exact tangent comparisons
    function automatic int unsigned grad_bin(input int unsigned l, r, u, d);
        logic [63:0] ax, ay;
        logic [35:0] tans [4];
        int unsigned above;
        tans[0] = TAN20;
        tans[1] = TAN40;
        tans[2] = TAN60;
        tans[3] = TAN80;
        ax = (r < l) ? 64'(l - r) : 64'(r - l);
        ay = (d >= u) ? 64'(d - u) : 64'(u - d);
        above = 0;
        for (int k = 0; k < 4; k++)
            if ((ay << 32) > ax * 64'(tans[k])) above++;
        return (r < l) ? 8 - above : above;
    endfunction

    // count one accepted pixel and queue the cells it releases
    task automatic count_pixel(input int unsigned l, r, u, d, col, row);
        int unsigned cw, ch, cell_idx, ncells, b;
        cell_hist_t  c;
        cw = (cellw_reg == 0) ? 1 : cellw_reg;
        ch = (cellh_reg == 0) ? 1 : cellh_reg;
        cell_idx = col / cw;
        if (cell_idx < MAX_CELLS) begin
            b = grad_bin(l, r, u, d);
            if (hist_model[cell_idx][b] != COUNT_MAX) hist_model[cell_idx][b]++;
        end
        // row end: last column of the image and last row of a cell
        if (col + 1 != width_reg || (row + 1) % ch != 0) return;
        ncells = (width_reg + cw - 1) / cw;
        if (ncells > MAX_CELLS) ncells = MAX_CELLS;
        for (int i = 0; i < ncells; i++) begin
            for (int k = 0; k < BIN_COUNT; k++) c.counts[k] = hist_model[i][k];
            c.cell_idx = 6'(i);
            c.last = (i + 1 == ncells);
            pending_cells.push_back(c);
        end
        for (int i = 0; i < MAX_CELLS; i++)
            for (int k = 0; k < BIN_COUNT; k++) hist_model[i][k] = '0;
    endtask

    // one pixel request, held until accepted
    task automatic send_pixel(input int unsigned l, r, u, d, col, row);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_left_pixel  <= 8'(l);
        s_right_pixel <= 8'(r);
        s_up_pixel    <= 8'(u);
        s_down_pixel  <= 8'(d);
        s_pixel_col   <= 10'(col);
        s_pixel_row   <= 10'(row);
        do @(posedge aclk); while (!s_ready);
        count_pixel(l, r, u, d, col, row);
    endtask

    // random neighbours, often with small gradients to land near the bin edges
    task automatic send_random_pixel(input int unsigned col, row);
        int unsigned l, r, u, d;
        l = $urandom_range(0, 255);
        u = $urandom_range(0, 255);
        if ($urandom_range(0, 2) == 0) begin
            r = (l + $urandom_range(0, 12)) & 8'hff;
            d = (u + $urandom_range(0, 12)) & 8'hff;
        end else begin
            r = $urandom_range(0, 255);
            d = $urandom_range(0, 255);
        end
        send_pixel(l, r, u, d, col, row);
    endtask

    // wait until the block is idle, then load all three registers
    task automatic load_geometry(input int unsigned iw, cw, ch);
        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= 11'(iw);
        @(posedge aclk);
        cfg_index <= CFG_CELL_WIDTH;
        cfg_data  <= 11'(cw);
        @(posedge aclk);
        cfg_index <= CFG_CELL_HEIGHT;
        cfg_data  <= 11'(ch);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        width_reg = 11'(iw);
        cellw_reg = 5'(cw);
        cellh_reg = 5'(ch);
    endtask

    // whole cell rows in raster order with a little out of order noise
    task automatic send_cell_rows(input int unsigned nrows, inout int unsigned sent);
        for (int unsigned cr = 0; cr < nrows; cr++) begin
            calm = ($urandom_range(0, 3) == 0);
            for (int unsigned y = cr * cellh_reg; y < (cr + 1) * cellh_reg; y++)
                for (int unsigned x = 0; x < width_reg; x++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_random_pixel($urandom_range(0, width_reg - 1),
                                          $urandom_range(0, 1023));
                        sent++;
                    end
                    send_random_pixel(x, y);
                    sent++;
                end
            calm = 1'b0;
            // now and then hold the sender until the row has drained
            if ($urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                while (pending_cells.size() != 0) @(posedge aclk);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // cell output: random stalls and in-order compare
    int unsigned ready_hold = 0;
    always @(posedge aclk) begin
        cell_hist_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.counts = {m_count_bin8, m_count_bin7, m_count_bin6, m_count_bin5,
                          m_count_bin4, m_count_bin3, m_count_bin2, m_count_bin1,
                          m_count_bin0};
            got.cell_idx = m_cell_col;
            got.last = m_row_done;
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected cell, cell_col", got.cell_idx, -1);
            end else begin
                want = pending_cells.pop_front();
                for (int k = 0; k < BIN_COUNT; k++)
                    if (got.counts[k] !== want.counts[k])
                        report_mismatch($sformatf("count_bin%0d of cell %0d", k,
                                                  want.cell_idx),
                                        got.counts[k], want.counts[k]);
                if (got.cell_idx !== want.cell_idx)
                    report_mismatch("cell_col", got.cell_idx, want.cell_idx);
                if (got.last !== want.last) report_mismatch("row_done", got.last, want.last);
            end
        end
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else begin
            ready_hold <= pick_gap();
            m_ready    <= 1'b1;
        end
    end

    // watchdog: ends the run when nothing moves for too long
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // directed gradients, each emitted as its own one pixel cell
    grad_case_t grad_cases [] = '{
        '{128, 128, 128, 128, 0},   // zero gradient
        '{0, 255, 0, 0, 0},         // largest positive gx
        '{255, 0, 0, 0, 8},         // pure negative gx is 180 degrees
        '{0, 0, 0, 255, 4},         // vertical, gy positive
        '{0, 0, 255, 0, 4},         // vertical, gy negative
        '{0, 0, 7, 8, 4},           // vertical, smallest gy
        '{0, 100, 0, 100, 2},       // 45 degrees
        '{100, 0, 0, 100, 6},       // 135 degrees
        '{100, 0, 100, 0, 6},
        '{0, 255, 0, 1, 0},
        '{255, 0, 0, 1, 8},
        '{0, 1, 0, 255, 4},
        '{1, 0, 0, 255, 4},
        '{255, 0, 0, 255, 6},
        '{0, 255, 0, 92, -1},       // either side of 20 degrees
        '{0, 255, 0, 93, -1},
        '{0, 255, 0, 214, -1},      // both just above 40 degrees
        '{0, 255, 0, 215, -1},
        '{0, 50, 0, 86, -1},        // either side of 60 degrees
        '{0, 50, 0, 87, -1},
        '{0, 44, 0, 249, -1},       // either side of 80 degrees
        '{0, 44, 0, 250, -1},
        '{0, 255, 255, 0, -1}
    };

    initial begin
        cell_hist_t  typed;
        int unsigned sent;
        for (int i = 0; i < MAX_CELLS; i++)
            for (int k = 0; k < BIN_COUNT; k++) hist_model[i][k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry 64 x 8 x 8: scattered pixels, then the row end
        repeat (30)
            send_random_pixel($urandom_range(0, 62), $urandom_range(0, 1023));
        send_random_pixel(63, 7);

        // one pixel cells: each directed gradient gives one cell
        load_geometry(1, 1, 1);
        foreach (grad_cases[i]) begin
            send_pixel(grad_cases[i].l, grad_cases[i].r, grad_cases[i].u, grad_cases[i].d,
                       0, 0);
            if (grad_cases[i].want_bin >= 0) begin
                typed.counts = '0;
                typed.counts[grad_cases[i].want_bin] = 9'd1;
                typed.cell_idx = '0;
                typed.last = 1'b1;
                pending_cells[pending_cells.size() - 1] = typed;
            end
        end

        // widest image, 16 x 16 cells: a full row of 64 cells
        load_geometry(1024, 16, 16);
        repeat (20)
            send_random_pixel($urandom_range(0, 1022), $urandom_range(0, 1023));
        send_random_pixel(1023, 15);

        // cells beyond storage are not counted, emission clamps at 64
        load_geometry(1024, 1, 1);
        repeat (12)
            send_random_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        send_random_pixel(1023, 1023);

        // zero sizes act as one and a zero width never ends a row
        load_geometry(0, 0, 0);
        repeat (10)
            send_random_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));

        // width above the image range, counts carry into the next geometry
        load_geometry(2047, 31, 31);
        repeat (10)
            send_random_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));

        // ragged width: partial last cell
        load_geometry(10, 4, 3);
        sent = 0;
        send_cell_rows(2, sent);

        // counter saturation: one cell gets more pixels than a counter holds
        load_geometry(64, 8, 8);
        calm = 1'b1;
        repeat (520) send_pixel(0, 255, 0, 0, 3, 2);
        calm = 1'b0;
        send_random_pixel(63, 15);

        // random geometries with raster cell rows
        sent = 0;
        while (sent < 320) begin
            case ($urandom_range(0, 5))
                0: load_geometry(16, 4, 2);
                1: load_geometry(12, 5, 3);
                2: load_geometry(8, 1, 1);
                3: load_geometry(24, 8, 4);
                4: load_geometry(20, 16, 1);
                default: load_geometry(9, 3, 5);
            endcase
            send_cell_rows($urandom_range(1, 3), sent);
        end

        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== hog_cell_orientation_histogram.f =====
+incdir+rtl
rtl/hog_pkg.sv
rtl/hog_ram.sv
rtl/hog_front.sv
rtl/hog_back.sv
rtl/hog_cell_orientation_histogram.sv
bench/hog_cell_orientation_histogram_test.sv
